>>> sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seismic sample converter
// Format codes and the packed result item.
// ----------------------------------------------------------------------------
`default_nettype none
package ssd_pkg;

  localparam logic [3:0] FMT_IBM    = 4'd1;
  localparam logic [3:0] FMT_INT32  = 4'd2;
  localparam logic [3:0] FMT_INT16  = 4'd3;
  localparam logic [3:0] FMT_SINGLE = 4'd5;
  localparam logic [3:0] FMT_DOUBLE = 4'd6;
  localparam logic [3:0] FMT_INT24  = 4'd7;
  localparam logic [3:0] FMT_INT8   = 4'd8;
  localparam logic [3:0] FMT_RESET  = FMT_IBM;

  typedef struct packed {
    logic [3:0]  sample_width;
    logic        format_ok;
    logic [63:0] value_bits;
  } result_t;

endpackage
`default_nettype wire

>>> sv/ssd_convert.sv
// ----------------------------------------------------------------------------
// ssd_convert: combinational sample decode
// Maps one raw big-endian sample to double bits for the selected format.
// ----------------------------------------------------------------------------
`default_nettype none
module ssd_convert (
  input  wire logic [3:0]     fmt,
  input  wire logic [63:0]    sample_bytes,
  output ssd_pkg::result_t    res
);

  // Sign/magnitude of the selected source; magnitude below 2^32.
  logic        neg;
  logic [31:0] mag;
  logic [4:0]  lead;
  logic        found;
  logic [10:0] bexp;
  logic [51:0] mant;
  logic [63:0] packed_bits;
  logic [31:0] w;
  logic [31:0] ibm_mag;
  logic [31:0] neg_mag;

  assign w = sample_bytes[63:32];

  // Unsigned magnitude and exponent bias for normalized packing.
  logic signed [12:0] scale;

  always_comb begin
    neg = 1'b0;
    mag = '0;
    scale = '0;
    ibm_mag = {8'd0, w[23:0]};
    neg_mag = '0;
    case (fmt)
      ssd_pkg::FMT_IBM: begin
        neg = w[31];
        mag = ibm_mag;
        scale = 13'sd4 * $signed({6'd0, w[30:24]}) - 13'sd280;
      end
      ssd_pkg::FMT_SINGLE: begin
        neg = w[31];
        mag = {9'd0, w[22:0]};
        scale = -13'sd149;
      end
      ssd_pkg::FMT_INT32: begin
        neg = w[31];
        mag = w[31] ? (~w + 32'd1) : w;
      end
      ssd_pkg::FMT_INT16: begin
        neg = w[31];
        neg_mag = {16'd0, ~w[31:16]} + 32'd1;
        mag = w[31] ? neg_mag : {16'd0, w[31:16]};
      end
      ssd_pkg::FMT_INT24: begin
        neg = w[31];
        neg_mag = {8'd0, ~w[31:8]} + 32'd1;
        mag = w[31] ? neg_mag : {8'd0, w[31:8]};
      end
      ssd_pkg::FMT_INT8: begin
        neg = w[31];
        neg_mag = {24'd0, ~w[31:24]} + 32'd1;
        mag = w[31] ? neg_mag : {24'd0, w[31:24]};
      end
      default: begin
        neg = 1'b0;
        mag = '0;
      end
    endcase
  end

  // Priority encoder on the magnitude.
  always_comb begin
    lead = '0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && mag[i]) begin
        lead = 5'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    logic [63:0] sh;
    sh = {32'd0, mag} << (6'd52 - {1'b0, lead});
    mant = sh[51:0];
    bexp = 11'(scale + 13'sd1023 + $signed({8'd0, lead}));
    packed_bits = found ? {neg, bexp, mant} : {neg, 63'd0};
  end

  always_comb begin
    res.value_bits = '0;
    res.format_ok = 1'b1;
    res.sample_width = 4'd4;
    case (fmt)
      ssd_pkg::FMT_IBM: res.value_bits = packed_bits;
      ssd_pkg::FMT_INT32, ssd_pkg::FMT_INT16, ssd_pkg::FMT_INT24,
      ssd_pkg::FMT_INT8: begin
        res.value_bits = found ? packed_bits : 64'd0;
        if (fmt == ssd_pkg::FMT_INT16) res.sample_width = 4'd2;
        if (fmt == ssd_pkg::FMT_INT24) res.sample_width = 4'd3;
        if (fmt == ssd_pkg::FMT_INT8)  res.sample_width = 4'd1;
      end
      ssd_pkg::FMT_SINGLE: begin
        if (w[30:23] == 8'hFF) begin
          res.value_bits = {w[31], 11'h7FF, w[22:0], 29'd0};
          if (w[22:0] != 23'd0) res.value_bits[51] = 1'b1;
        end else if (w[30:23] == 8'h00) begin
          res.value_bits = packed_bits;
        end else begin
          res.value_bits = {w[31], 11'({3'd0, w[30:23]} + 11'd896), w[22:0], 29'd0};
        end
      end
      ssd_pkg::FMT_DOUBLE: begin
        res.value_bits = sample_bytes;
        res.sample_width = 4'd8;
      end
      default: begin
        res.format_ok = 1'b0;
        res.sample_width = 4'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sv/seismic_sample_to_double.sv
// Seismic sample to IEEE double converter.
// Stages: input register, result register. Throughput: one beat per cycle
// while the receiver accepts; a stall on m_tready holds the stream.
// Reset: rst (synchronous) empties both stages and sets the format to IBM.
// ----------------------------------------------------------------------------
// seismic_sample_to_double: stream top level
// Input register, decode logic, output register with elastic handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module seismic_sample_to_double (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,     // sample_format
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,       // sample_bytes
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [71:0] m_tdata        // value_bits, format_ok, sample_width, pad
);

  logic [3:0]        sample_format;
  logic              in_valid;
  logic [63:0]       in_data;
  logic              out_valid;
  ssd_pkg::result_t  out_res;
  ssd_pkg::result_t  res;
  logic              out_load;
  logic              in_adv;

  always_ff @(posedge clk) begin
    if (rst) sample_format <= ssd_pkg::FMT_RESET;
    else if (cfg_we) sample_format <= cfg_wdata;
  end

  // Output stage frees when empty or drained this cycle.
  assign out_load = !out_valid || m_tready;
  // Input stage advances when empty or its beat moves to output.
  assign in_adv   = !in_valid || out_load;
  assign s_tready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= s_tvalid;
    end
    if (in_adv) in_data <= s_tdata;
  end

  ssd_convert u_conv (
    .fmt          (sample_format),
    .sample_bytes (in_data),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
    if (out_load) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res.sample_width, out_res.format_ok, out_res.value_bits};

endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for seismic_sample_to_double
// Drives raw trace samples under the defined format codes and undefined ones
// and checks each converted beat against a built-in model of the conversion,
// with random idling on both sides of the stream.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = 64'd0;        // sample_bytes
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;                // value_bits, format_ok, sample_width, pad

  seismic_sample_to_double dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model copy of the format register
  logic [3:0]       fmt_shadow;
  ssd_pkg::result_t expected_q[$];
  int               mismatches = 0;
  int               beats_sent = 0;
  int               beats_checked = 0;
  int               send_idle_pct = 0;   // sender idle chance, percent
  int               recv_stall_pct = 0;  // receiver stall chance, percent
  bit [15:0]        fmt_seen = '0;

  // Double bits for (-1)^neg * mag * 2^scale, mag nonzero and below 2^52.
  function automatic logic [63:0] pack_dbl(bit neg, logic [63:0] mag, int scale);
    int p;
    logic [63:0] mant;
    logic [10:0] bexp;
    p = 0;
    for (int i = 0; i < 64; i++)
      if (mag[i]) p = i;
    bexp = 11'(p + scale + 1023);
    mant = (mag << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF;
    return {neg, bexp, mant[51:0]};
  endfunction

  // two's complement of width w, taken from the low bits of raw
  function automatic logic [63:0] int_to_dbl(logic [63:0] raw, int w);
    logic [63:0] mask, mag;
    bit neg;
    mask = (64'd1 << w) - 64'd1;
    raw &= mask;
    neg = raw[w-1];
    mag = neg ? ((~raw + 64'd1) & mask) : raw;
    if (neg && mag == 0) mag = 64'd1 << (w - 1);
    if (mag == 0) return 64'd0;
    return pack_dbl(neg, mag, 0);
  endfunction

  function automatic logic [63:0] ibm_to_dbl(logic [31:0] w);
    if (w[23:0] == 0) return {w[31], 63'd0};  // signed zero, any exponent
    return pack_dbl(w[31], {40'd0, w[23:0]}, 4 * int'(w[30:24]) - 280);
  endfunction

  function automatic logic [63:0] single_to_dbl(logic [31:0] w);
    logic [10:0] ex;
    if (w[30:23] == 8'hFF) begin
      if (w[22:0] == 0) return {w[31], 11'h7FF, 52'd0};
      return {w[31], 11'h7FF, 1'b1, w[21:0], 29'd0} | {12'd0, w[22], 51'd0};
    end
    if (w[30:23] == 0) begin
      if (w[22:0] == 0) return {w[31], 63'd0};
      return pack_dbl(w[31], {41'd0, w[22:0]}, -149);  // subnormal -> normal
    end
    ex = 11'(w[30:23]) - 11'd127 + 11'd1023;
    return {w[31], ex, w[22:0], 29'd0};
  endfunction

  function automatic ssd_pkg::result_t convert_sample(logic [3:0] f, logic [63:0] s);
    ssd_pkg::result_t r;
    r.format_ok = 1'b1;
    case (f)
      ssd_pkg::FMT_IBM: begin
        r.value_bits = ibm_to_dbl(s[63:32]);    r.sample_width = 4'd4;
      end
      ssd_pkg::FMT_INT32: begin
        r.value_bits = int_to_dbl(s >> 32, 32); r.sample_width = 4'd4;
      end
      ssd_pkg::FMT_INT16: begin
        r.value_bits = int_to_dbl(s >> 48, 16); r.sample_width = 4'd2;
      end
      ssd_pkg::FMT_SINGLE: begin
        r.value_bits = single_to_dbl(s[63:32]); r.sample_width = 4'd4;
      end
      ssd_pkg::FMT_DOUBLE: begin
        r.value_bits = s;                       r.sample_width = 4'd8;
      end
      ssd_pkg::FMT_INT24: begin
        r.value_bits = int_to_dbl(s >> 40, 24); r.sample_width = 4'd3;
      end
      ssd_pkg::FMT_INT8: begin
        r.value_bits = int_to_dbl(s >> 56, 8);  r.sample_width = 4'd1;
      end
      default: begin
        r.value_bits = 64'd0; r.format_ok = 1'b0; r.sample_width = 4'd0;
      end
    endcase
    return r;
  endfunction

  // Send one sample; idle gaps before it per send_idle_pct. tvalid stays
  // high afterwards so the next sample can follow back to back.
  task automatic send_sample(logic [63:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(convert_sample(fmt_shadow, s));
    beats_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid before any wait that is not a send.
  task automatic stop_send();
    s_tvalid <= 1'b0;
  endtask

  // Receiver side: random stall, sampled at falling edge, checked at rising.
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    ssd_pkg::result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[68:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", m_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        beats_checked++;
        if (got.value_bits !== exp_r.value_bits || got.format_ok !== exp_r.format_ok ||
            got.sample_width !== exp_r.sample_width) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp bits=%h ok=%b w=%0d, got bits=%h ok=%b w=%0d",
                     exp_r.value_bits, exp_r.format_ok, exp_r.sample_width,
                     got.value_bits, got.format_ok, got.sample_width);
        end
      end
    end
  end

  // Wait for the pipe to drain, then write the format register.
  task automatic set_format(logic [3:0] f);
    stop_send();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_we <= 1'b0;
    fmt_shadow = f;
    fmt_seen[f] = 1'b1;
  endtask

  // Random sample biased toward the interesting corners of each format.
  function automatic logic [63:0] rand_sample();
    logic [63:0] s;
    s = {$urandom, $urandom};
    case ($urandom_range(7))
      0: s[55:32] = 24'd0;                 // zero fraction / zero low bytes
      1: s[62:55] = 8'hFF;                 // single inf/NaN
      2: s[62:55] = 8'h00;                 // single zero/subnormal
      3: s[62:52] = 11'h7FF;               // double inf/NaN
      4: s[62:32] = '1;
      default: ;
    endcase
    return s;
  endfunction

  task automatic test_directed();
    logic [63:0] corners[12] = '{64'd0, '1, 64'h8000_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h4110_0000_0000_0000, 64'hC000_0000_0000_0000,
      64'h7F80_0000_0000_0000, 64'h7FC0_0000_0000_0000, 64'h7F80_0001_0000_0000,
      64'h0000_0001_0000_0000, 64'h8080_0000_0000_0000, 64'h0012_3456_89AB_CDEF};
    logic [3:0] fmts[9] = '{ssd_pkg::FMT_IBM, ssd_pkg::FMT_INT32, ssd_pkg::FMT_INT16,
      ssd_pkg::FMT_SINGLE, ssd_pkg::FMT_DOUBLE, ssd_pkg::FMT_INT24, ssd_pkg::FMT_INT8,
      4'd0, 4'd15};
    // reset format is IBM: a couple of samples before any write
    send_sample(corners[4]);
    send_sample(corners[2]);
    foreach (fmts[i]) begin
      set_format(fmts[i]);
      for (int k = 0; k < (i < 3 ? 3 : 2); k++)
        send_sample(corners[$urandom_range(11)]);
    end
  endtask

  // One random phase: a few format changes, given idling percentages.
  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) set_format(4'($urandom_range(15)));
      send_sample(rand_sample());
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Sender holds off until every expected beat has come back.
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_sample(rand_sample());
    stop_send();
    while (expected_q.size() != 0) @(negedge clk);
    for (int i = 0; i < 20; i++) send_sample(rand_sample());
  endtask

  initial begin
    fmt_shadow = ssd_pkg::FMT_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phase(360, 0, 0);
    test_random_phase(340, 87, 0);
    test_random_phase(340, 0, 87);
    test_random_phase(340, 30, 30);
    test_drain_pause();
    stop_send();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("ran %0d samples, %0d checked, format codes seen mask %h",
             beats_sent, beats_checked, fmt_seen);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("seismic_sample_to_double verification clean");
    else
      $display("seismic_sample_to_double verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("seismic_sample_to_double verification failed");
    $finish;
  end
endmodule
`default_nettype wire
